// ----- rtl/bpu_pkg.sv -----
`default_nettype none

package bpu_pkg;

    // Widths fixed by the item fields.
    localparam int PROB_W = 17;
    localparam int CNT_W  = 6;

    // Distribution values are unsigned Q0.31 and may reach exactly 1.0.
    localparam int DIST_W = 32;
    localparam int PROD_W = 2 * DIST_W;

    localparam logic [DIST_W-1:0] ONE_Q31   = 32'h8000_0000;
    localparam logic [PROB_W-1:0] ONE_Q16   = 17'h1_0000;
    localparam logic [DIST_W:0]   ROUND_Q15 = 33'h0_0000_4000;

    // Function selector codes.
    typedef enum logic [1:0] {
        FUNC_POINT = 2'd0,
        FUNC_LOWER = 2'd1,
        FUNC_UPPER = 2'd2
    } func_t;

endpackage

`default_nettype wire

// ----- rtl/binomial_probability_unit_top.sv -----
`default_nettype none

// Binomial probability unit. Each accepted item carries a success probability
// p (unsigned Q0.16, 65536 is 1.0), a trial count n, a success count r and a
// function selector, and yields one item holding P(X=r), P(X<=r) or P(X>=r)
// in unsigned Q0.16, saturated at 1.0; an unknown selector yields 0. A p above
// 1.0 is taken as 1.0 and n above MAX_TRIALS is taken as MAX_TRIALS. The
// distribution is built trial by trial in Q0.31 with the recurrence
// f[j] = f[j]*(1-p) + f[j-1]*p in a small memory of MAX_TRIALS+1 entries, with
// a single 32x32 multiplier shared by both products of every update. Each
// update does two multiplies and a write back. Summing the requested terms
// then reads the memory once per term. The input is stalled for the whole
// computation of an item, while a finished result waits in the output
// register without blocking the next item from being accepted.
module binomial_probability_unit_top #(
    parameter int MAX_TRIALS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  func,
    input  wire logic [16:0] prob_success,
    input  wire logic [5:0]  trials,
    input  wire logic [5:0]  successes,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [16:0]      probability_out
);

    // Memory geometry follows from the largest trial count.
    localparam int DEPTH = MAX_TRIALS + 1;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CW    = bpu_pkg::CNT_W;
    localparam int DW    = bpu_pkg::DIST_W;
    localparam int PW    = bpu_pkg::PROD_W;
    localparam int QW    = bpu_pkg::PROB_W;
    localparam logic [CW-1:0] MAX_N = CW'(MAX_TRIALS);

    // The sequencer walks through init, the per-trial update loop (read,
    // multiply, write back), the summation loop, and the result hand-off.
    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_RD,
        S_MB,
        S_WR,
        S_SUM_SET,
        S_SUM_RD,
        S_SUM_ACC
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]    func_reg, func_next;
    logic [DW-1:0] p_reg, p_next;
    logic [DW-1:0] q_reg, q_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] r_reg, r_next;
    logic [CW-1:0] t_reg, t_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [DW-1:0] cur_reg, cur_next;
    logic [PW-1:0] prod_reg, prod_next;
    logic [PW-1:0] acc_reg, acc_next;
    logic [DW-1:0] sum_reg, sum_next;
    logic          done_reg, done_next;
    logic          out_valid_reg, out_valid_next;
    logic [QW-1:0] probability_out_reg, probability_out_next;

    // Distribution memory: one write port, one registered read port.
    logic [DW-1:0]    dist_mem [0:DEPTH-1];
    logic [DW-1:0]    mem_rd_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [IDX_W-1:0] mem_raddr;
    logic [DW-1:0]    mem_wdata;

    // Shared multiplier operands and product.
    logic [DW-1:0] mul_a;
    logic [DW-1:0] mul_b;
    logic [PW-1:0] mul_prod;

    logic [QW-1:0]   p_clamped;
    logic [CW-1:0]   n_clamped;
    logic [DW-1:0]   lower_term;
    logic [PW-1:0]   update_sum;
    logic [CW-1:0]   tail_top;
    logic [DW:0]     rounded_sum;
    logic [DW-15:0]  rounded_q16;
    logic [QW-1:0]   result_q16;

    always_comb
    begin
        p_clamped = (prob_success > bpu_pkg::ONE_Q16) ? bpu_pkg::ONE_Q16 : prob_success;
        n_clamped = (trials > MAX_N) ? MAX_N : trials;
    end

    assign mul_prod = PW'(mul_a) * PW'(mul_b);

    // At j = 0 the lower neighbor is zero.
    assign lower_term = (j_reg == '0) ? '0 : mem_rd_reg;
    assign update_sum = acc_reg + prod_reg;
    assign tail_top   = (r_reg < n_reg) ? r_reg : n_reg;

    // Round Q0.31 to nearest Q0.16 and saturate at 1.0.
    assign rounded_sum = {1'b0, sum_reg} + bpu_pkg::ROUND_Q15;
    assign rounded_q16 = rounded_sum[DW:15];
    assign result_q16  = (rounded_q16 > (DW-14)'(bpu_pkg::ONE_Q16)) ?
                         bpu_pkg::ONE_Q16 : rounded_q16[QW-1:0];

    always_comb
    begin
        state_next           = state_reg;
        func_next            = func_reg;
        p_next               = p_reg;
        q_next               = q_reg;
        n_next               = n_reg;
        r_next               = r_reg;
        t_next               = t_reg;
        j_next               = j_reg;
        idx_next             = idx_reg;
        hi_next              = hi_reg;
        cur_next             = cur_reg;
        prod_next            = prod_reg;
        acc_next             = acc_reg;
        sum_next             = sum_reg;
        done_next            = done_reg;
        probability_out_next = probability_out_reg;
        out_valid_next       = out_valid_reg && out_stall;

        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_raddr = '0;
        mul_a     = cur_reg;
        mul_b     = q_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next  = func;
                    p_next     = {p_clamped, 15'd0};
                    q_next     = bpu_pkg::ONE_Q31 - {p_clamped, 15'd0};
                    n_next     = n_clamped;
                    r_next     = successes;
                    state_next = S_INIT;
                end
            end

            S_INIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = bpu_pkg::ONE_Q31;
                t_next    = CW'(1);
                j_next    = CW'(1);
                cur_next  = '0;
                state_next = (n_reg == '0) ? S_SUM_SET : S_RD;
            end

            S_RD:
            begin
                // Old f[j] times q; fetch old f[j-1].
                mul_a      = cur_reg;
                mul_b      = q_reg;
                prod_next  = mul_prod;
                mem_raddr  = (j_reg == '0) ? '0 : IDX_W'(j_reg - CW'(1));
                state_next = S_MB;
            end

            S_MB:
            begin
                // Old f[j-1] times p; it is the old f[j] of the next step.
                mul_a      = lower_term;
                mul_b      = p_reg;
                acc_next   = prod_reg;
                prod_next  = mul_prod;
                cur_next   = lower_term;
                state_next = S_WR;
            end

            S_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = IDX_W'(j_reg);
                mem_wdata = update_sum[2*DW-2:DW-1];
                if (j_reg != '0)
                begin
                    j_next     = j_reg - CW'(1);
                    state_next = S_RD;
                end
                else if (t_reg == n_reg)
                begin
                    state_next = S_SUM_SET;
                end
                else
                begin
                    t_next     = t_reg + CW'(1);
                    j_next     = t_reg + CW'(1);
                    cur_next   = '0;
                    state_next = S_RD;
                end
            end

            S_SUM_SET:
            begin
                sum_next   = '0;
                state_next = S_SUM_RD;
                case (bpu_pkg::func_t'(func_reg))
                    bpu_pkg::FUNC_POINT:
                    begin
                        idx_next = r_reg;
                        hi_next  = r_reg;
                        if (r_reg > n_reg)
                        begin
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    bpu_pkg::FUNC_LOWER:
                    begin
                        idx_next = '0;
                        hi_next  = tail_top;
                    end
                    bpu_pkg::FUNC_UPPER:
                    begin
                        idx_next = r_reg;
                        hi_next  = n_reg;
                        if (r_reg > n_reg)
                        begin
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    default:
                    begin
                        idx_next   = '0;
                        hi_next    = '0;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_SUM_RD:
            begin
                mem_raddr  = IDX_W'(idx_reg);
                state_next = S_SUM_ACC;
            end

            S_SUM_ACC:
            begin
                sum_next = sum_reg + mem_rd_reg;
                if (idx_reg == hi_reg)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_SUM_RD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A finished result waits here until the output register is free.
        // While it waits, the input is held off.
        if (done_reg)
        begin
            state_next = S_IDLE;
            if (!out_valid_reg || !out_stall)
            begin
                probability_out_next = result_q16;
                out_valid_next       = 1'b1;
                done_next            = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg            <= func_next;
        p_reg               <= p_next;
        q_reg               <= q_next;
        n_reg               <= n_next;
        r_reg               <= r_next;
        t_reg               <= t_next;
        j_reg               <= j_next;
        idx_reg             <= idx_next;
        hi_reg              <= hi_next;
        cur_reg             <= cur_next;
        prod_reg            <= prod_next;
        acc_reg             <= acc_next;
        sum_reg             <= sum_next;
        probability_out_reg <= probability_out_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            dist_mem[mem_waddr] <= mem_wdata;
        end
        mem_rd_reg <= dist_mem[mem_raddr];
    end

    assign in_stall        = (state_reg != S_IDLE) || done_reg;
    assign out_valid       = out_valid_reg;
    assign probability_out = probability_out_reg;

    // The result never exceeds one.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (probability_out <= bpu_pkg::ONE_Q16))
        else $error("result above one");

    // The update loop stays inside the current trial and the trial count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD) |-> ((j_reg <= t_reg) && (t_reg <= n_reg)
                                 && (t_reg != '0)))
        else $error("update index out of range");

    // Summation only reads built entries of the requested range.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SUM_RD) |-> ((idx_reg <= hi_reg) && (hi_reg <= n_reg)))
        else $error("sum index out of range");

    // The clamped trial count always fits the memory.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (n_reg <= MAX_N))
        else $error("trial count beyond memory");

    // A pending result leaves at the first free output slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (!out_valid_reg || !out_stall)) |=> (out_valid_reg && !done_reg))
        else $error("result not handed off");

endmodule

`default_nettype wire

// ----- bench/binomial_probability_unit_checker.sv -----
`timescale 1ns / 100ps

// Watches both channels of the binomial probability unit, predicts the result
// of every accepted query and compares it with the result items as they leave.
module binomial_probability_unit_checker #(
    parameter int MAX_TRIALS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [1:0]  func,
    input  wire logic [16:0] prob_success,
    input  wire logic [5:0]  trials,
    input  wire logic [5:0]  successes,

    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [16:0] probability_out,

    output int               pending,
    output int               errors
);

    typedef struct {
        logic [1:0]  func;
        logic [16:0] prob;
        logic [5:0]  trials;
        logic [5:0]  successes;
        logic [16:0] probability;
    } query_t;

    query_t expected_probs[$];
    query_t head;
    query_t query;
    int     fail_count = 0;

    // Builds the distribution trial by trial in Q0.31, truncating after each
    // trial, then sums the selected terms and rounds to Q0.16.
    function automatic logic [16:0] binomial_prob(input logic [1:0] f, input logic [16:0] p,
                                                  input logic [5:0] n_in, input logic [5:0] r_in);
        logic [63:0] pmf [0:MAX_TRIALS];
        logic [63:0] p31;
        logic [63:0] q31;
        logic [63:0] acc;
        logic [63:0] total;
        logic [63:0] rounded;
        int          n;
        int          r;
        int          top;
        p31 = (p > bpu_pkg::ONE_Q16) ? (64'(bpu_pkg::ONE_Q16) << 15) : (64'(p) << 15);
        q31 = 64'(bpu_pkg::ONE_Q31) - p31;
        n = (n_in > MAX_TRIALS) ? MAX_TRIALS : int'(n_in);
        r = int'(r_in);
        for (int j = 0; j <= MAX_TRIALS; j++)
            pmf[j] = 64'd0;
        pmf[0] = 64'(bpu_pkg::ONE_Q31);
        for (int t = 1; t <= n; t++)
        begin
            for (int j = t; j > 0; j--)
            begin
                acc = pmf[j] * q31 + pmf[j-1] * p31;
                pmf[j] = acc >> 31;
            end
            pmf[0] = (pmf[0] * q31) >> 31;
        end
        total = 64'd0;
        if (f == bpu_pkg::FUNC_POINT)
        begin
            if (r <= n)
                total = pmf[r];
        end
        else if (f == bpu_pkg::FUNC_LOWER)
        begin
            top = (r < n) ? r : n;
            for (int j = 0; j <= top; j++)
                total = total + pmf[j];
        end
        else if (f == bpu_pkg::FUNC_UPPER)
        begin
            for (int j = r; j <= n; j++)
                total = total + pmf[j];
        end
        rounded = (total + 64'd16384) >> 15;
        if (rounded > 64'(bpu_pkg::ONE_Q16))
            rounded = 64'(bpu_pkg::ONE_Q16);
        return rounded[16:0];
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                query.func        = func;
                query.prob        = prob_success;
                query.trials      = trials;
                query.successes   = successes;
                query.probability = binomial_prob(func, prob_success, trials, successes);
                expected_probs.push_back(query);
            end
            if (out_valid && !out_stall)
            begin
                if (expected_probs.size() == 0)
                begin
                    $error("unexpected result item: probability_out %0d", probability_out);
                    fail_count++;
                end
                else
                begin
                    head = expected_probs.pop_front();
                    if (head.probability !== probability_out)
                    begin
                        $error({"probability_out mismatch: expected %0d, actual %0d ",
                                "(func %0d p %0d n %0d r %0d)"},
                               head.probability, probability_out, head.func, head.prob,
                               head.trials, head.successes);
                        fail_count++;
                    end
                end
            end
            pending <= expected_probs.size();
            errors  <= fail_count;
        end
    end

endmodule

// ----- bench/binomial_probability_unit_top_tb.sv -----
`timescale 1ns / 100ps

// Testbench for the binomial probability unit. This module only makes
// stimulus and gives the verdict; the checker instance next to the block
// predicts every result and counts the failures.
module binomial_probability_unit_top_tb;

    localparam int MAX_TRIALS = 32;

    // The block has no code for the fourth selector value; it must yield 0.
    localparam logic [1:0] FUNC_UNKNOWN = 2'd3;

    // The drain wait covers the slowest item (32 trials, full tail), and the
    // limit takes the slowest run of about 1025 items with the longest gaps on
    // both sides several times over.
    localparam int DRAIN_CYCLES = 2000;
    localparam int CYCLE_LIMIT  = 10_000_000;
    localparam int RANDOM_ITEMS = 1000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    // All inputs of the block start at known values.
    logic        in_valid = 1'b0;
    logic [1:0]  func = bpu_pkg::FUNC_POINT;
    logic [16:0] prob_success = 17'd0;
    logic [5:0]  trials = 6'd0;
    logic [5:0]  successes = 6'd0;
    logic        out_stall = 1'b0;

    wire logic        in_stall;
    wire logic        out_valid;
    wire logic [16:0] probability_out;

    int pending;
    int errors;

    // When set, neither side idles, which gives back-to-back stretches.
    logic no_idle = 1'b0;

    int sink_hold = 0;
    int hold_draw = 0;
    int cycle_count = 0;

    binomial_probability_unit_top #(
        .MAX_TRIALS(MAX_TRIALS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .func(func),
        .prob_success(prob_success),
        .trials(trials),
        .successes(successes),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .probability_out(probability_out)
    );

    binomial_probability_unit_checker #(
        .MAX_TRIALS(MAX_TRIALS)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .func(func),
        .prob_success(prob_success),
        .trials(trials),
        .successes(successes),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .probability_out(probability_out),
        .pending(pending),
        .errors(errors)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // The run is cut off if it takes far longer than any correct run could.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("binomial_probability_unit_top verification failed");
            $finish;
        end
    end

    // Result side. After every accepted result a random hold is drawn. With a
    // nonzero hold the stall stays high from the handshake on, through the whole
    // computation of the next item, and then while the next valid result counts
    // the hold down. This lets the next item be accepted while a finished
    // result is still held back.
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            hold_draw = no_idle ? 0 : $urandom_range(0, 12);
            sink_hold <= hold_draw;
            out_stall <= (hold_draw != 0);
        end
        else if (out_valid && out_stall)
        begin
            sink_hold <= sink_hold - 1;
            out_stall <= (sink_hold > 1);
        end
    end

    // Offers one query item after a random gap and returns at the edge where
    // it is accepted. With a zero gap the valid stays high from the previous
    // item, so it is never lowered and raised in the same step.
    task automatic send_query(input logic [1:0] f, input logic [16:0] p,
                              input logic [5:0] n, input logic [5:0] r);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        func         <= f;
        prob_success <= p;
        trials       <= n;
        successes    <= r;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Waits until the checker holds no expected result. The count is registered
    // in the checker, so the task waits for an edge before its first look.
    task automatic wait_for_results();
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    initial
    begin : stimulus
        logic [1:0]  f;
        logic [16:0] p;
        logic [5:0]  n;
        logic [5:0]  r;
        int          n_eff;
        int          roll;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: zero trials, both extremes of p, a p above one, more
        // trials than the block supports, success counts beyond the trial
        // count and the unknown selector.
        send_query(bpu_pkg::FUNC_POINT, 17'd0,      6'd0,  6'd0);
        send_query(bpu_pkg::FUNC_POINT, 17'd32768,  6'd0,  6'd1);
        send_query(bpu_pkg::FUNC_LOWER, 17'd12345,  6'd0,  6'd0);
        send_query(bpu_pkg::FUNC_UPPER, 17'd12345,  6'd0,  6'd0);
        send_query(bpu_pkg::FUNC_LOWER, 17'd65536,  6'd32, 6'd32);
        send_query(bpu_pkg::FUNC_UPPER, 17'd32768,  6'd32, 6'd0);
        send_query(bpu_pkg::FUNC_POINT, 17'd32768,  6'd32, 6'd16);
        send_query(bpu_pkg::FUNC_POINT, 17'd65536,  6'd5,  6'd5);
        send_query(bpu_pkg::FUNC_POINT, 17'd0,      6'd5,  6'd0);
        send_query(bpu_pkg::FUNC_POINT, 17'd131071, 6'd10, 6'd10);
        send_query(bpu_pkg::FUNC_LOWER, 17'd65537,  6'd7,  6'd3);
        send_query(bpu_pkg::FUNC_POINT, 17'd30000,  6'd63, 6'd32);
        send_query(bpu_pkg::FUNC_UPPER, 17'd40000,  6'd40, 6'd20);
        send_query(bpu_pkg::FUNC_POINT, 17'd20000,  6'd5,  6'd9);
        send_query(bpu_pkg::FUNC_UPPER, 17'd20000,  6'd5,  6'd6);
        send_query(bpu_pkg::FUNC_LOWER, 17'd20000,  6'd5,  6'd63);
        send_query(FUNC_UNKNOWN, 17'd32768, 6'd8, 6'd4);
        send_query(FUNC_UNKNOWN, 17'd0,     6'd0, 6'd0);
        send_query(bpu_pkg::FUNC_LOWER, 17'd1,      6'd32, 6'd0);
        send_query(bpu_pkg::FUNC_UPPER, 17'd65535,  6'd63, 6'd63);
        send_query(bpu_pkg::FUNC_POINT, 17'd1,      6'd32, 6'd1);
        send_query(bpu_pkg::FUNC_POINT, 17'd65535,  6'd32, 6'd31);

        // The sender holds off here until every result has come back.
        in_valid <= 1'b0;
        wait_for_results();

        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            // Every fourth block of 50 items runs with no idling on either side.
            no_idle <= ((k % 200) >= 150);

            roll = $urandom_range(0, 99);
            if (roll < 30)
                f = bpu_pkg::FUNC_POINT;
            else if (roll < 62)
                f = bpu_pkg::FUNC_LOWER;
            else if (roll < 95)
                f = bpu_pkg::FUNC_UPPER;
            else
                f = FUNC_UNKNOWN;

            // Mostly p within range, with the extremes and raw 17-bit values
            // (many of them above one) now and then.
            roll = $urandom_range(0, 99);
            if (roll < 4)
                p = 17'd0;
            else if (roll < 8)
                p = 17'd65536;
            else if (roll < 10)
                p = 17'd1;
            else if (roll < 12)
                p = 17'd65535;
            else if (roll < 22)
                p = 17'($urandom_range(0, 131071));
            else
                p = 17'($urandom_range(0, 65536));

            // Most items use few trials to keep the run short; some use the
            // full range of the field, clamped ones among them.
            roll = $urandom_range(0, 99);
            if (roll < 70)
                n = 6'($urandom_range(0, 12));
            else if (roll < 92)
                n = 6'($urandom_range(0, 63));
            else
                n = 6'($urandom_range(28, 63));

            n_eff = (n > MAX_TRIALS) ? MAX_TRIALS : int'(n);
            if ($urandom_range(0, 99) < 80)
                r = 6'($urandom_range(0, n_eff + 1));
            else
                r = 6'($urandom_range(0, 63));

            send_query(f, p, n, r);

            if ((k % 250) == 249)
            begin
                in_valid <= 1'b0;
                wait_for_results();
            end
        end

        in_valid <= 1'b0;
        no_idle <= 1'b0;
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("binomial_probability_unit_top verification clean");
        else
            $display("binomial_probability_unit_top verification failed");
        $finish;
    end

endmodule
